>>> rtl/acse_pkg.sv
`default_nettype none

package acse_pkg;

  localparam int MAX_TONES       = 4;
  localparam int SINE_TABLE_BITS = 10;

  localparam int TONE_AW   = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
  localparam int TONE_CW   = $clog2(MAX_TONES + 1);
  localparam int CNT_W     = 24;
  localparam int MG_W      = 15;
  localparam int SUM_MAG_W = 31 + TONE_CW;
  localparam int SUM_W     = SUM_MAG_W + 1;
  localparam int DVD_W     = SUM_MAG_W + CNT_W;
  localparam int DCNT_W    = $clog2(SUM_MAG_W + 1);
  localparam int SC_W      = SUM_MAG_W + MG_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [15:0] SIN_A    = 16'd51472;
  localparam logic [14:0] SIN_B    = 15'd21024;
  localparam logic [11:0] SIN_C    = 12'd2320;
  localparam logic [15:0] GAIN_ONE = 16'h8000;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_START = 2'd2
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TONE_COUNT   = 3'd0,
    CFG_MASTER_GAIN  = 3'd1,
    CFG_NOTE_SAMPLES = 3'd2,
    CFG_ATTACK       = 3'd3,
    CFG_DECAY        = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_PH,
    ST_SW,
    ST_MAC,
    ST_ACC,
    ST_ENV1,
    ST_ENV2,
    ST_MUL,
    ST_DVS,
    ST_DIV,
    ST_SCL,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  tone_index;
    logic [31:0] phase_step;
    logic [15:0] tone_gain;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               note_end;
  } out_item_t;

  typedef struct packed {
    logic [31:0] step;
    logic [15:0] gain;
  } tone_entry_t;

endpackage

`default_nettype wire

>>> rtl/acse_sine.sv
`default_nettype none

module acse_sine (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic [31:0]        phase_i,
  output logic                    out_valid_o,
  output logic signed [15:0]      sample_o
);

  localparam int STB = acse_pkg::SINE_TABLE_BITS;
  localparam int FW  = STB - 2;
  localparam int ZW  = 17 - STB;

  logic [STB-1:0] idx;
  logic [15:0]    x_raw;
  logic [15:0]    x_in;

  logic [4:0]     vld_q;
  logic [15:0]    x0_q, x1_q, x2_q, x3_q;
  logic [3:0]     neg_q;
  logic [15:0]    sq1_q, sq2_q;
  logic [14:0]    bt_q;
  logic [15:0]    av_q;
  logic signed [15:0] s_q;

  logic [31:0]    p1;
  logic [27:0]    p2;
  logic [30:0]    p3;
  logic [31:0]    p4;
  logic [14:0]    v3;
  logic [16:0]    y4;
  logic [14:0]    ymag;

  assign idx   = phase_i[31 -: STB];
  assign x_raw = {1'b0, idx[FW-1:0], {ZW{1'b0}}};
  assign x_in  = idx[STB-2] ? (acse_pkg::GAIN_ONE - x_raw) : x_raw;

  assign p1   = 32'(x0_q) * 32'(x0_q);
  assign p2   = 28'(sq1_q) * 28'(acse_pkg::SIN_C);
  assign p3   = 31'(sq2_q) * 31'(bt_q);
  assign v3   = p3[29:15];
  assign p4   = 32'(x3_q) * 32'(av_q);
  assign y4   = p4[31:15];
  assign ymag = (y4 > 17'd32767) ? 15'h7fff : y4[14:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q     <= x_in;
    neg_q[0] <= idx[STB-1];

    x1_q     <= x0_q;
    sq1_q    <= p1[30:15];
    neg_q[1] <= neg_q[0];

    x2_q     <= x1_q;
    sq2_q    <= sq1_q;
    bt_q     <= acse_pkg::SIN_B - {3'b000, p2[26:15]};
    neg_q[2] <= neg_q[1];

    x3_q     <= x2_q;
    av_q     <= acse_pkg::SIN_A - {1'b0, v3};
    neg_q[3] <= neg_q[2];

    s_q      <= neg_q[3] ? -$signed({1'b0, ymag}) : $signed({1'b0, ymag});
  end

  assign out_valid_o = vld_q[4];
  assign sample_o    = s_q;

endmodule

`default_nettype wire

>>> rtl/acse_div.sv
`default_nettype none

module acse_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [acse_pkg::DVD_W-1:0]    dividend_i,
  input  wire logic [acse_pkg::CNT_W-1:0]    divisor_i,
  output logic                               done_o,
  output logic [acse_pkg::SUM_MAG_W-1:0]     quotient_o
);

  localparam int QW = acse_pkg::SUM_MAG_W;
  localparam int DW = acse_pkg::CNT_W;
  localparam int CW = acse_pkg::DCNT_W;

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, den_q;
  logic [QW-1:0] sr_q;

  logic [DW:0]   trial;
  logic          ge;
  logic [DW:0]   rem_n;

  // restoring division, one quotient bit per cycle; quotient fits QW bits
  assign trial = {rem_q, sr_q[QW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_n = ge ? (trial - {1'b0, den_q}) : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[acse_pkg::DVD_W-1 -: DW];
      sr_q  <= dividend_i[QW-1:0];
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_n[DW-1:0];
      sr_q  <= {sr_q[QW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = sr_q;

endmodule

`default_nettype wire

>>> rtl/additive_chord_synth_envelope.sv
// Load and start items are handled in the idle state, as is a tick past the end of the note.
// A tick in the note is accepted, then each summed tone has a table read, the 5-stage
// sine pipeline, a gain multiply and an accumulate, and each unused table entry a table read;
// envelope, bit-serial divide and master scaling follow (the last step waits while the output is stalled).
// One item in flight; the output register holds a result while the next item is taken.
// Reset: registers to 0 / master_gain 8190, counter and phases zero; tone table undefined.
`default_nettype none

module additive_chord_synth_envelope (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire acse_pkg::in_item_t                  in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output acse_pkg::out_item_t                      out_data_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [acse_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [acse_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int NT   = acse_pkg::MAX_TONES;
  localparam int AW   = acse_pkg::TONE_AW;
  localparam int CW   = acse_pkg::CNT_W;
  localparam int MW   = acse_pkg::SUM_MAG_W;
  localparam int SW   = acse_pkg::SUM_W;
  localparam int DVW  = acse_pkg::DVD_W;
  localparam int SCW  = acse_pkg::SC_W;
  localparam int MVW  = SCW - 30;

  acse_pkg::state_e state_q, state_d;

  // configuration
  logic [2:0]               tcnt_q;
  logic [acse_pkg::MG_W-1:0] mg_q;
  logic [CW-1:0]            nn_q, aa_q, dd_q;

  // tone and phase memories
  acse_pkg::tone_entry_t    tone_mem [NT];
  logic [31:0]              phase_mem [NT];
  acse_pkg::tone_entry_t    tone_rd_q;
  logic [31:0]              phase_rd_q;
  logic                     rd_vld_q;
  logic [NT-1:0]            ph_vld_q;

  logic [AW-1:0]            tone_q;
  logic [CW-1:0]            cnt_q;

  logic                     in_acc;
  logic                     load_ok;
  logic                     tone_we;
  logic                     ph_we;
  logic                     start_clr;
  logic                     tick_go;
  logic                     use_tone;
  logic                     last_tone;
  logic                     sine_go;
  logic                     div_go;
  logic                     fin_go;
  logic [31:0]              ph_eff;
  logic [15:0]              gain_clamp;

  logic                     sine_vld;
  logic signed [15:0]       sine_s;

  logic [15:0]              gain_q;
  logic signed [32:0]       mac_full;
  logic signed [31:0]       prod_q;
  logic signed [SW-1:0]     sum_q;
  logic [MW-1:0]            sum_mag;
  logic                     neg_q;

  logic                     d_gt_n;
  logic [CW-1:0]            n_min_d;
  logic [CW-1:0]            dp_d, ap_d, dp_q, ap_q;
  logic [CW-1:0]            num_d, den_d, num_q, den_q;
  logic [DVW-1:0]           mul_q;
  logic                     div_done;
  logic [MW-1:0]            quo;
  logic [SCW-1:0]           sc_q;
  logic [MVW-1:0]           mag_v;
  logic [15:0]              sat_v;

  logic                     out_valid_q;
  acse_pkg::out_item_t      out_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign load_ok = 32'(in_data_i.tone_index) < NT;
  assign tick_go = in_acc && (in_data_i.opcode == acse_pkg::OP_TICK) && (cnt_q < nn_q);
  assign use_tone  = 32'(tone_q) < 32'(tcnt_q);
  assign last_tone = tone_q == AW'(NT - 1);
  assign ph_eff    = rd_vld_q ? phase_rd_q : 32'd0;
  assign gain_clamp = (tone_rd_q.gain > acse_pkg::GAIN_ONE) ? acse_pkg::GAIN_ONE
                                                           : tone_rd_q.gain;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      acse_pkg::ST_IDLE: if (tick_go) state_d = acse_pkg::ST_RD;
      acse_pkg::ST_RD:   state_d = acse_pkg::ST_PH;
      acse_pkg::ST_PH: begin
        if (use_tone) begin
          state_d = acse_pkg::ST_SW;
        end else if (last_tone) begin
          state_d = acse_pkg::ST_ENV1;
        end else begin
          state_d = acse_pkg::ST_RD;
        end
      end
      acse_pkg::ST_SW:   if (sine_vld) state_d = acse_pkg::ST_MAC;
      acse_pkg::ST_MAC:  state_d = acse_pkg::ST_ACC;
      acse_pkg::ST_ACC:  state_d = last_tone ? acse_pkg::ST_ENV1 : acse_pkg::ST_RD;
      acse_pkg::ST_ENV1: state_d = acse_pkg::ST_ENV2;
      acse_pkg::ST_ENV2: state_d = acse_pkg::ST_MUL;
      acse_pkg::ST_MUL:  state_d = acse_pkg::ST_DVS;
      acse_pkg::ST_DVS:  state_d = acse_pkg::ST_DIV;
      acse_pkg::ST_DIV:  if (div_done) state_d = acse_pkg::ST_SCL;
      acse_pkg::ST_SCL:  state_d = acse_pkg::ST_FIN;
      acse_pkg::ST_FIN:  if (fin_go) state_d = acse_pkg::ST_IDLE;
      default:           state_d = acse_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    tone_we    = 1'b0;
    start_clr  = 1'b0;
    ph_we      = 1'b0;
    sine_go    = 1'b0;
    div_go     = 1'b0;
    fin_go     = 1'b0;
    case (state_q)
      acse_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        tone_we    = in_acc && (in_data_i.opcode == acse_pkg::OP_LOAD) && load_ok;
        start_clr  = in_acc && (in_data_i.opcode == acse_pkg::OP_START);
      end
      acse_pkg::ST_PH: begin
        ph_we   = 1'b1;
        sine_go = use_tone;
      end
      acse_pkg::ST_DVS: div_go = 1'b1;
      acse_pkg::ST_FIN: fin_go = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= acse_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcnt_q <= '0;
      mg_q   <= 15'd8190;
      nn_q   <= '0;
      aa_q   <= '0;
      dd_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        acse_pkg::CFG_TONE_COUNT:   tcnt_q <= cfg_wdata_i[2:0];
        acse_pkg::CFG_MASTER_GAIN:  mg_q   <= cfg_wdata_i[acse_pkg::MG_W-1:0];
        acse_pkg::CFG_NOTE_SAMPLES: nn_q   <= cfg_wdata_i[CW-1:0];
        acse_pkg::CFG_ATTACK:       aa_q   <= cfg_wdata_i[CW-1:0];
        acse_pkg::CFG_DECAY:        dd_q   <= cfg_wdata_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // memories: registered read at the current tone, write on load / phase update
  always_ff @(posedge clk_i) begin
    if (tone_we) begin
      tone_mem[AW'(in_data_i.tone_index)] <= '{step: in_data_i.phase_step,
                                                gain: in_data_i.tone_gain};
    end
    if (ph_we) begin
      phase_mem[tone_q] <= ph_eff + tone_rd_q.step;
    end
    tone_rd_q  <= tone_mem[tone_q];
    phase_rd_q <= phase_mem[tone_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_vld_q <= '0;
      rd_vld_q <= 1'b0;
      tone_q   <= '0;
      cnt_q    <= '0;
    end else begin
      rd_vld_q <= ph_vld_q[tone_q];
      if (start_clr) begin
        ph_vld_q <= '0;
        cnt_q    <= '0;
      end else if (ph_we) begin
        ph_vld_q[tone_q] <= 1'b1;
      end
      if (tick_go) begin
        tone_q <= '0;
      end else if ((state_q == acse_pkg::ST_PH && !use_tone && !last_tone) ||
                   (state_q == acse_pkg::ST_ACC && !last_tone)) begin
        tone_q <= tone_q + AW'(1);
      end
      if (fin_go) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  acse_sine u_sine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sine_go),
    .phase_i     (ph_eff),
    .out_valid_o (sine_vld),
    .sample_o    (sine_s)
  );

  // tone sum
  assign mac_full = sine_s * $signed({1'b0, gain_q});
  assign sum_mag  = sum_q[SW-1] ? MW'(-sum_q) : MW'(sum_q);

  // envelope
  assign d_gt_n  = dd_q > nn_q;
  assign n_min_d = nn_q - dd_q;
  assign dp_d    = d_gt_n ? '0 : n_min_d;
  assign ap_d    = (d_gt_n || (aa_q > n_min_d)) ? dp_d : aa_q;

  always_comb begin
    if (cnt_q < ap_q) begin
      num_d = cnt_q;
      den_d = ap_q;
    end else if (cnt_q < dp_q) begin
      num_d = CW'(1);
      den_d = CW'(1);
    end else begin
      num_d = nn_q - cnt_q;
      den_d = nn_q - dp_q;
    end
    if (den_d == '0) begin
      num_d = '0;
      den_d = CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_go) begin
      sum_q <= '0;
    end else if (state_q == acse_pkg::ST_ACC) begin
      sum_q <= sum_q + {{(SW-32){prod_q[31]}}, prod_q};
    end
    if (state_q == acse_pkg::ST_PH) begin
      gain_q <= gain_clamp;
    end
    if (state_q == acse_pkg::ST_MAC) begin
      prod_q <= mac_full[31:0];
    end
    if (state_q == acse_pkg::ST_ENV1) begin
      dp_q <= dp_d;
      ap_q <= ap_d;
    end
    if (state_q == acse_pkg::ST_ENV2) begin
      num_q <= num_d;
      den_q <= den_d;
    end
    if (state_q == acse_pkg::ST_MUL) begin
      mul_q <= DVW'(sum_mag) * DVW'(num_q);
      neg_q <= sum_q[SW-1];
    end
    if (state_q == acse_pkg::ST_SCL) begin
      sc_q <= SCW'(quo) * SCW'(mg_q);
    end
  end

  acse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (mul_q),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // scale down by 2^30 toward zero, then saturate
  assign mag_v = sc_q[SCW-1:30];

  always_comb begin
    if (!neg_q) begin
      sat_v = (mag_v > MVW'(32767)) ? 16'h7fff : mag_v[15:0];
    end else begin
      sat_v = (mag_v > MVW'(32768)) ? 16'h8000 : (16'd0 - mag_v[15:0]);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_q.sample   <= $signed(sat_v);
      out_q.note_end <= (cnt_q + CW'(1)) == nn_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> verif/acse_sample_checker.sv
module acse_sample_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  acse_pkg::in_item_t                in_data_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  acse_pkg::out_item_t               out_data_i,
  input  logic                              cfg_we_i,
  input  logic [acse_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [acse_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output int                                pending_o,
  output int                                errors_o
);

  import acse_pkg::*;

  logic [2:0]  tone_cnt_q;
  logic [14:0] master_gain_q;
  logic [23:0] note_len_q;
  logic [23:0] attack_len_q;
  logic [23:0] decay_len_q;

  logic [31:0] step_q  [MAX_TONES];
  logic [15:0] gain_q  [MAX_TONES];
  logic [31:0] phase_q [MAX_TONES];
  logic [23:0] sample_cnt_q;

  out_item_t sample_q [$];
  int        fail_cnt;

  function automatic longint sine_q15(logic [31:0] ph);
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                 quad;
    longint unsigned            x, x2, t, v, y;
    idx  = ph[31 -: SINE_TABLE_BITS];
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    x    = idx[SINE_TABLE_BITS-3:0];
    x    = x << (17 - SINE_TABLE_BITS);
    if (quad[0]) x = longint'(GAIN_ONE) - x;
    x2 = (x * x) >> 15;
    t  = (x2 * longint'(SIN_C)) >> 15;
    v  = (x2 * (longint'(SIN_B) - t)) >> 15;
    y  = (x * (longint'(SIN_A) - v)) >> 15;
    if (y > 32767) y = 32767;
    return quad[1] ? -longint'(y) : longint'(y);
  endfunction

  // Expected sample for a tick inside the note, from the current state.
  function automatic out_item_t tick_result();
    out_item_t res;
    longint    acc, g, num, den, e, v, nn, na, nd, n, dp, ap;
    int        cnt, k;
    acc = 0;
    cnt = (tone_cnt_q > MAX_TONES) ? MAX_TONES : int'(tone_cnt_q);
    for (k = 0; k < cnt; k++) begin
      g   = (gain_q[k] > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(gain_q[k]);
      acc = acc + sine_q15(phase_q[k]) * g;
    end
    nn = longint'(note_len_q);
    na = longint'(attack_len_q);
    nd = longint'(decay_len_q);
    n  = longint'(sample_cnt_q);
    dp = (nd > nn) ? 0 : nn - nd;
    ap = (na > nn - nd) ? dp : na;
    if (n < ap) begin
      num = n;
      den = ap;
    end else if (n < dp) begin
      num = 1;
      den = 1;
    end else begin
      num = nn - n;
      den = nn - dp;
    end
    if (den <= 0) begin
      num = 0;
      den = 1;
    end
    e = (acc * num) / den;
    v = (e * longint'(master_gain_q)) / 64'sd1073741824;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    res.sample   = v[15:0];
    res.note_end = (({1'b0, sample_cnt_q} + 25'd1) == {1'b0, note_len_q});
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t got, want;
    int        k;
    if (!rst_ni) begin
      tone_cnt_q    = '0;
      master_gain_q = 15'd8190;
      note_len_q    = '0;
      attack_len_q  = '0;
      decay_len_q   = '0;
      for (k = 0; k < MAX_TONES; k++) begin
        step_q[k]  = '0;
        gain_q[k]  = '0;
        phase_q[k] = '0;
      end
      sample_cnt_q = '0;
      sample_q.delete();
      fail_cnt     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (sample_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected transfer, expected none, actual sample %0d note_end %0b",
                   $time, got.sample, got.note_end);
        end else begin
          want = sample_q.pop_front();
          if (got.sample !== want.sample) begin
            fail_cnt++;
            $display("%0t: sample mismatch, expected %0d actual %0d",
                     $time, want.sample, got.sample);
          end
          if (got.note_end !== want.note_end) begin
            fail_cnt++;
            $display("%0t: note_end mismatch, expected %0b actual %0b",
                     $time, want.note_end, got.note_end);
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TONE_COUNT:   tone_cnt_q    = cfg_wdata_i[2:0];
          CFG_MASTER_GAIN:  master_gain_q = cfg_wdata_i[14:0];
          CFG_NOTE_SAMPLES: note_len_q    = cfg_wdata_i[23:0];
          CFG_ATTACK:       attack_len_q  = cfg_wdata_i[23:0];
          CFG_DECAY:        decay_len_q   = cfg_wdata_i[23:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        case (in_data_i.opcode)
          OP_LOAD: begin
            step_q[in_data_i.tone_index] = in_data_i.phase_step;
            gain_q[in_data_i.tone_index] = in_data_i.tone_gain;
          end
          OP_START: begin
            sample_cnt_q = '0;
            for (k = 0; k < MAX_TONES; k++) phase_q[k] = '0;
          end
          OP_TICK: begin
            if (sample_cnt_q < note_len_q) begin
              sample_q.push_back(tick_result());
              for (k = 0; k < MAX_TONES; k++) phase_q[k] = phase_q[k] + step_q[k];
              sample_cnt_q = sample_cnt_q + 24'd1;
            end
          end
          default: ;
        endcase
      end
    end
    pending_o <= sample_q.size();
    errors_o  <= fail_cnt;
  end

endmodule

>>> verif/testbench.sv
module testbench;

  import acse_pkg::*;

  localparam logic [1:0] OP_NOP     = 2'd3;
  localparam int         CYCLE_CAP  = 2000000;
  localparam int         TAIL_WAIT  = 150;
  localparam int         HOLD_LEN   = 500;
  localparam int         PHASES     = 10;
  localparam int         PHASE_ITEMS = 200;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  int pending;
  int errors;
  int cycle_cnt;

  // sender shaping
  int burst_left;
  bit gap_free;
  bit hold_req;

  // copy of the note length last written, used to size notes
  int note_len_cfg;

  additive_chord_synth_envelope dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  acse_sample_checker sample_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic in_item_t mk(logic [1:0] op, logic [1:0] ti, logic [31:0] st,
                                  logic [15:0] g);
    in_item_t it;
    it.opcode     = op;
    it.tone_index = ti;
    it.phase_step = st;
    it.tone_gain  = g;
    return it;
  endfunction

  function automatic logic [31:0] rand_step();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 32'h0;
      1:       return 32'h4000_0000;
      2:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 16'd0;
      1:       return GAIN_ONE;
      2:       return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic send(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gap_free ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_tick();
    send(mk(OP_TICK, 2'($urandom()), $urandom(), 16'($urandom())));
  endtask

  task automatic send_load();
    send(mk(OP_LOAD, 2'($urandom()), rand_step(), rand_gain()));
  endtask

  // Wait until every expected result is back, then let any in-flight item finish.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (pending != 0);
    repeat (TAIL_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic write_regs(int tc, int mg, int nl, int al, int dl);
    write_reg(CFG_TONE_COUNT,   {21'($urandom()), 3'(tc)});
    write_reg(CFG_MASTER_GAIN,  {9'($urandom()), 15'(mg)});
    write_reg(CFG_NOTE_SAMPLES, 24'(nl));
    write_reg(CFG_ATTACK,       24'(al));
    write_reg(CFG_DECAY,        24'(dl));
    cfg_we_i <= 1'b0;
    note_len_cfg = nl;
  endtask

  // Mostly complete notes with random content, plus loads, noise and cut-short notes.
  task automatic play(int budget);
    int sent, n, k, r;
    sent = 0;
    if ($urandom_range(0, 1) == 1) begin
      n = $urandom_range(0, 8);
      for (k = 0; k < n; k++) send_tick();
    end
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_load();
        sent++;
      end else if (r < 10) begin
        send(mk(OP_NOP, 2'($urandom()), $urandom(), 16'($urandom())));
      end else begin
        send(mk(OP_START, 2'($urandom()), $urandom(), 16'($urandom())));
        sent++;
        n = (note_len_cfg <= 64) ? note_len_cfg + $urandom_range(0, 2)
                                 : $urandom_range(16, 64);
        if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 29) == 0) begin
            send_load();
            sent++;
          end
          send_tick();
          sent++;
        end
      end
    end
  endtask

  // receiver
  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       hold_left;
    int       period;
    int       phase_cnt;
    bit       hold_seen;
    mode_left = 0;
    hold_left = 0;
    period    = 4;
    phase_cnt = 0;
    hold_seen = 1'b0;
    mode      = RX_OPEN;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(50, 400);
          period    = $urandom_range(2, 9);
        end
        mode_left--;
        phase_cnt++;
        case (mode)
          RX_OPEN:     out_stall_i <= 1'b0;
          RX_LIGHT:    out_stall_i <= ($urandom_range(0, 99) < 30);
          RX_HEAVY:    out_stall_i <= ($urandom_range(0, 99) < 80);
          RX_PERIODIC: out_stall_i <= ((phase_cnt % period) < (period / 2));
          default:     out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // stimulus
  initial begin
    int p, k, tc, mg, nl, al, dl;
    cycle_cnt    = 0;
    burst_left   = 0;
    gap_free     = 1'b0;
    hold_req     = 1'b0;
    note_len_cfg = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: empty note, tick gives nothing; fill the whole table
    send_tick();
    send(mk(OP_LOAD, 2'd0, 32'h0000_0000, GAIN_ONE));
    send(mk(OP_LOAD, 2'd1, 32'hFFFF_FFFF, 16'hFFFF));
    send(mk(OP_LOAD, 2'd2, 32'h4000_0000, 16'd0));
    send(mk(OP_LOAD, 2'd3, $urandom(), 16'd16384));
    send(mk(OP_NOP, 2'd3, 32'hFFFF_FFFF, 16'hFFFF));
    drain();

    // oversized tone count, full gain; ticks before any start run off the reset state
    write_regs(7, 32767, 6, 2, 2);
    for (k = 0; k < 7; k++) send_tick();
    send(mk(OP_START, 2'd0, 32'h0, 16'h0));
    for (k = 0; k < 3; k++) send_tick();
    send(mk(OP_LOAD, 2'd2, 32'h0100_0000, 16'hFFFF));
    for (k = 0; k < 4; k++) send_tick();
    send(mk(OP_START, 2'd3, 32'h0, 16'h0));
    drain();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin tc = 4; mg = 32760; nl = 32; al = 8; dl = 8; end
        1: begin tc = 7; mg = 32767; nl = 20; al = 0; dl = 0; end
        2: begin tc = 0; mg = $urandom_range(0, 32767); nl = 10; al = 3; dl = 3; end
        3: begin tc = $urandom_range(1, 3); mg = 0; nl = 16; al = 4; dl = 6; end
        4: begin tc = 4; mg = $urandom_range(0, 32767); nl = 12;
                 al = 24'hFF_FFFF; dl = 24'hFF_FFFF; end
        5: begin tc = 3; mg = 32760; nl = 25; al = 30; dl = 5; end
        6: begin tc = 4; mg = 32767; nl = 24'hFF_FFFF; al = 24'hFF_FFFF; dl = 0; end
        7: begin tc = 4; mg = 32760; nl = 1; al = 1; dl = 1; end
        default: begin
          tc = $urandom_range(0, 7);
          mg = $urandom_range(0, 32767);
          nl = $urandom_range(1, 64);
          al = $urandom_range(0, nl + 4);
          dl = $urandom_range(0, nl + 4);
        end
      endcase
      write_regs(tc, mg, nl, al, dl);
      gap_free = (p % 4 == 1);
      if (p == 0) hold_req = 1'b1;
      play(PHASE_ITEMS);
      drain();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/acse_pkg.sv
rtl/acse_sine.sv
rtl/acse_div.sv
rtl/additive_chord_synth_envelope.sv
verif/acse_sample_checker.sv
verif/testbench.sv
